// ----- sv/rgbhsv_pkg.sv -----
// rgbhsv_pkg: widths, sector codes and the cell link type of the rgb to hsv pipeline
// depends on nothing; imported by every module of the block
package rgbhsv_pkg;

  localparam int CHANNEL_FRAC_BITS = 15;
  localparam int HUE_BITS          = 16;
  localparam int FIELD_W           = 16;

  localparam int CW    = CHANNEL_FRAC_BITS + 1;
  localparam int QS    = CHANNEL_FRAC_BITS + 1;
  localparam int NSTEP = (QS > HUE_BITS) ? QS : HUE_BITS;
  localparam int DW    = $clog2(6 * (1 << CHANNEL_FRAC_BITS) + 1);
  localparam int CMPW  = (CW > FIELD_W) ? CW : FIELD_W;

  localparam logic [CMPW-1:0] ONE_CMP = CMPW'(1) << CHANNEL_FRAC_BITS;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic             vld;
    logic [DW-1:0]    rem_h;
    logic [DW-1:0]    div_h;
    logic [DW-1:0]    rem_s;
    logic [DW-1:0]    div_s;
    logic [NSTEP-1:0] quo_h;
    logic [NSTEP-1:0] quo_s;
    logic [CW-1:0]    val;
  } cell_t;

endpackage

// ----- sv/rgbhsv_front.sv -----
// rgbhsv_front: two stage front end, clamp, max and min, chroma, hue numerator, divisors
// depends on rgbhsv_pkg; feeds the first divider cell
module rgbhsv_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [15:0]           red_i,
  input  logic [15:0]           green_i,
  input  logic [15:0]           blue_i,
  output rgbhsv_pkg::cell_t     cell_o
);
  import rgbhsv_pkg::*;

  logic [CW-1:0] r_c, g_c, b_c, v_c, mn_c;
  sector_e       sec_c;

  logic          vld_a_q;
  logic [CW-1:0] r_a_q, g_a_q, b_a_q, v_a_q, c_a_q;
  sector_e       sec_a_q;

  logic [DW-1:0] c_w, six_c, base, x_w, y_w, num;
  cell_t         cell_d, cell_q;

  function automatic logic [CW-1:0] clamp_ch(input logic [15:0] in);
    logic [CMPW-1:0] w;
    w = CMPW'(in);
    return (w > ONE_CMP) ? CW'(ONE_CMP) : CW'(w);
  endfunction

  always_comb begin
    r_c = clamp_ch(red_i);
    g_c = clamp_ch(green_i);
    b_c = clamp_ch(blue_i);
    if (r_c >= g_c && r_c >= b_c) begin
      v_c   = r_c;
      sec_c = SEC_RED;
    end else if (g_c >= b_c) begin
      v_c   = g_c;
      sec_c = SEC_GREEN;
    end else begin
      v_c   = b_c;
      sec_c = SEC_BLUE;
    end
    mn_c = (r_c <= g_c) ? ((r_c <= b_c) ? r_c : b_c) : ((g_c <= b_c) ? g_c : b_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_a_q   <= r_c;
    g_a_q   <= g_c;
    b_a_q   <= b_c;
    v_a_q   <= v_c;
    c_a_q   <= v_c - mn_c;
    sec_a_q <= sec_c;
  end

  // numerator stays in [0, 6c), so modular arithmetic is exact
  always_comb begin
    c_w   = DW'(c_a_q);
    six_c = (c_w << 2) + (c_w << 1);
    unique case (sec_a_q)
      SEC_RED: begin
        base = (g_a_q < b_a_q) ? six_c : '0;
        x_w  = DW'(g_a_q);
        y_w  = DW'(b_a_q);
      end
      SEC_GREEN: begin
        base = c_w << 1;
        x_w  = DW'(b_a_q);
        y_w  = DW'(r_a_q);
      end
      SEC_BLUE: begin
        base = c_w << 2;
        x_w  = DW'(r_a_q);
        y_w  = DW'(g_a_q);
      end
      default: begin
        base = '0;
        x_w  = '0;
        y_w  = '0;
      end
    endcase
    num = base + x_w - y_w;

    cell_d       = '0;
    cell_d.vld   = vld_a_q;
    cell_d.val   = v_a_q;
    cell_d.rem_h = (c_a_q == '0) ? '0 : num;
    cell_d.div_h = (c_a_q == '0) ? DW'(1) : six_c;
    cell_d.rem_s = c_w;
    cell_d.div_s = (v_a_q == '0) ? DW'(1) : (DW'(v_a_q) << 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- sv/rgbhsv_cell.sv -----
// rgbhsv_cell: one restoring division step for hue and for saturation, registered
// depends on rgbhsv_pkg; chained by the top level
module rgbhsv_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rgbhsv_pkg::cell_t cell_i,
  output rgbhsv_pkg::cell_t cell_o
);
  import rgbhsv_pkg::*;

  logic [DW:0] sh_h, sh_s;
  logic        bit_h, bit_s;
  cell_t       cell_d, cell_q;

  always_comb begin
    sh_h   = {cell_i.rem_h, 1'b0};
    sh_s   = {cell_i.rem_s, 1'b0};
    bit_h  = (sh_h >= {1'b0, cell_i.div_h});
    bit_s  = (sh_s >= {1'b0, cell_i.div_s});
    cell_d = cell_i;
    cell_d.rem_h = bit_h ? DW'(sh_h - {1'b0, cell_i.div_h}) : DW'(sh_h);
    cell_d.rem_s = bit_s ? DW'(sh_s - {1'b0, cell_i.div_s}) : DW'(sh_s);
    cell_d.quo_h = {cell_i.quo_h[NSTEP-2:0], bit_h};
    cell_d.quo_s = {cell_i.quo_s[NSTEP-2:0], bit_s};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- sv/rgb_to_hsv_pixel.sv -----
// rgb_to_hsv_pixel: rgb to hexcone hsv, two front stages then a chain of divider cells
// result: valid_o is the vld bit of the last cell, carried through both front stages and every divider cell
// throughput: one transaction per cycle, set by one quotient bit per cell; busy stays low
// reset: clears the valid of the first front stage, the whole second front stage and every cell, no result follows
// the receiver cannot stall, so results leave on a fixed schedule
// depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_cell
module rgb_to_hsv_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  output logic        valid_o,
  output logic [15:0] hue_o,
  output logic [15:0] saturation_o,
  output logic [15:0] brightness_o
);
  import rgbhsv_pkg::*;

  cell_t              link [NSTEP+1];
  logic [HUE_BITS-1:0] hue_full;
  logic [QS-1:0]       sat_full;

  assign busy = 1'b0;

  rgbhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start && !busy),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .cell_o  (link[0])
  );

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[i]),
      .cell_o (link[i+1])
    );
  end

  assign hue_full     = link[NSTEP].quo_h[NSTEP-1 -: HUE_BITS];
  assign sat_full     = link[NSTEP].quo_s[NSTEP-1 -: QS];
  assign valid_o      = link[NSTEP].vld;
  assign hue_o        = 16'(hue_full);
  assign saturation_o = 16'(sat_full);
  assign brightness_o = 16'(link[NSTEP].val);

endmodule
